/* sv/utf8v_pkg.sv */
`default_nettype none

package utf8v_pkg;

   // Width of the reported line number on the result port
   localparam int ERROR_LINE_WIDTH = 24;

   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK  = 2'd0;
   localparam status_type STATUS_BOM = 2'd1;
   localparam status_type STATUS_BAD = 2'd2;

   typedef struct packed {
      status_type                  status;
      logic [ERROR_LINE_WIDTH-1:0] error_line;
      logic [7:0]                  bad_value;
   } verdict_type;

endpackage

`default_nettype wire

/* sv/utf8v_scan.sv */
`default_nettype none

// Per-byte UTF-8 checker: holds the stream state, updates it once per
// request and forms the verdict on the final byte.
module utf8v_scan #(
   parameter int LINE_WIDTH = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  end_of_stream,
   output utf8v_pkg::verdict_type     verdict,
   output logic                       verdict_valid
);

   typedef enum logic [1:0] {
      MODE_SCANNING,
      MODE_STOPPED,
      MODE_ERROR
   } mode_type;

   localparam logic [1:0] PREFIX_LAST = 2'd2;
   localparam logic [1:0] PREFIX_DONE = 2'd3;

   localparam logic [7:0] BOM_0      = 8'hEF;
   localparam logic [7:0] BOM_1      = 8'hBB;
   localparam logic [7:0] BOM_2      = 8'hBF;
   localparam logic [7:0] NEWLINE    = 8'h0A;
   localparam logic [7:0] MASK_3     = 8'hE0;
   localparam logic [7:0] MASK_4     = 8'hF0;
   localparam logic [7:0] MASK_5     = 8'hF8;
   localparam logic [7:0] MASK_2     = 8'hC0;
   localparam logic [7:0] MASK_7     = 8'hFE;
   localparam logic [7:0] LEAD_2     = 8'hC0;
   localparam logic [7:0] LEAD_3     = 8'hE0;
   localparam logic [7:0] LEAD_4     = 8'hF0;
   localparam logic [7:0] LEAD_MAX   = 8'hF4;
   localparam logic [7:0] LEAD_ED    = 8'hED;
   localparam logic [7:0] LEAD_EF    = 8'hEF;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] SURR_TAG   = 8'hA0;
   localparam logic [7:0] CONT_TOP   = 8'hBF;
   localparam logic [7:0] NONCHAR    = 8'hBE;
   localparam logic [7:0] F4_LIMIT   = 8'h8F;

   localparam logic [LINE_WIDTH-1:0] LINE_ONE = LINE_WIDTH'(1);

   logic [LINE_WIDTH-1:0] line_count_ff, line_count_in;
   logic [LINE_WIDTH-1:0] lead_line_ff, lead_line_in;
   logic [LINE_WIDTH-1:0] err_line_ff, err_line_in;
   logic [7:0]            lead_value_ff, lead_value_in;
   logic [7:0]            second_value_ff, second_value_in;
   logic [7:0]            err_value_ff, err_value_in;
   logic [1:0]            pending_ff, pending_in;
   logic [1:0]            prefix_pos_ff, prefix_pos_in;
   logic                  bom_seen_ff, bom_seen_in;
   mode_type              mode_ff, mode_in;

   logic [7:0]                             bom_expect;
   logic [2:0]                             seq_len;
   logic [2:0]                             cont_pos;
   logic                                   cont_bad;
   logic [utf8v_pkg::ERROR_LINE_WIDTH-1:0] err_line_sat;
   logic                                   verdict_eos;

   always_comb begin
      case (prefix_pos_ff)
         2'd0:    bom_expect = BOM_0;
         2'd1:    bom_expect = BOM_1;
         default: bom_expect = BOM_2;
      endcase
      if ((lead_value_ff & MASK_3) == LEAD_2) begin
         seq_len = 3'd2;
      end else if ((lead_value_ff & MASK_4) == LEAD_3) begin
         seq_len = 3'd3;
      end else begin
         seq_len = 3'd4;
      end
      cont_pos = seq_len - {1'b0, pending_ff};
   end

   always_comb begin
      line_count_in   = line_count_ff;
      lead_line_in    = lead_line_ff;
      err_line_in     = err_line_ff;
      lead_value_in   = lead_value_ff;
      second_value_in = second_value_ff;
      err_value_in    = err_value_ff;
      pending_in      = pending_ff;
      prefix_pos_in   = prefix_pos_ff;
      bom_seen_in     = bom_seen_ff;
      mode_in         = mode_ff;
      cont_bad        = 1'b0;

      // byte-order mark match on the first three bytes
      if (prefix_pos_ff != PREFIX_DONE) begin
         if (data_byte == bom_expect) begin
            if (prefix_pos_ff == PREFIX_LAST) bom_seen_in = 1'b1;
            prefix_pos_in = prefix_pos_ff + 2'd1;
         end else begin
            prefix_pos_in = PREFIX_DONE;
         end
      end

      if (mode_ff == MODE_SCANNING) begin
         if (pending_ff == 2'd0) begin
            lead_value_in = data_byte;
            lead_line_in  = line_count_ff;
            if (data_byte == 8'd0) begin
               mode_in = MODE_STOPPED;
            end else if (!data_byte[7]) begin
               if (data_byte == NEWLINE && !(&line_count_ff))
                  line_count_in = line_count_ff + LINE_ONE;
            end else if ((data_byte & MASK_3) == LEAD_2) begin
               if ((data_byte & MASK_7) == LEAD_2) begin
                  mode_in      = MODE_ERROR;
                  err_line_in  = line_count_ff;
                  err_value_in = data_byte;
               end else begin
                  pending_in = 2'd1;
               end
            end else if ((data_byte & MASK_4) == LEAD_3) begin
               pending_in = 2'd2;
            end else if ((data_byte & MASK_5) == LEAD_4 && data_byte <= LEAD_MAX) begin
               pending_in = 2'd3;
            end else begin
               // stray continuation, F5..FF
               mode_in      = MODE_ERROR;
               err_line_in  = line_count_ff;
               err_value_in = data_byte;
            end
         end else begin
            cont_bad = (data_byte & MASK_2) != CONT_TAG;
            if (cont_pos == 3'd1) begin
               if (lead_value_ff == LEAD_3 && (data_byte & MASK_3) == CONT_TAG)
                  cont_bad = 1'b1;
               if (lead_value_ff == LEAD_ED && (data_byte & MASK_3) == SURR_TAG)
                  cont_bad = 1'b1;
               if (lead_value_ff == LEAD_4 && (data_byte & MASK_4) == CONT_TAG)
                  cont_bad = 1'b1;
               if (lead_value_ff == LEAD_MAX && data_byte > F4_LIMIT)
                  cont_bad = 1'b1;
               second_value_in = data_byte;
            end else if (cont_pos == 3'd2 && seq_len == 3'd3) begin
               if (lead_value_ff == LEAD_EF && second_value_ff == CONT_TOP &&
                   (data_byte & MASK_7) == NONCHAR)
                  cont_bad = 1'b1;
            end
            if (cont_bad) begin
               mode_in      = MODE_ERROR;
               err_line_in  = lead_line_ff;
               err_value_in = lead_value_ff;
               pending_in   = 2'd0;
            end else begin
               pending_in = pending_ff - 2'd1;
            end
         end
      end

      // stream ends inside a sequence
      if (end_of_stream && mode_in == MODE_SCANNING && pending_in != 2'd0) begin
         mode_in      = MODE_ERROR;
         err_line_in  = lead_line_in;
         err_value_in = lead_value_in;
         pending_in   = 2'd0;
      end
   end

   generate
      if (LINE_WIDTH > utf8v_pkg::ERROR_LINE_WIDTH) begin : g_sat
         assign err_line_sat =
            (|err_line_in[LINE_WIDTH-1:utf8v_pkg::ERROR_LINE_WIDTH]) ?
            '1 : err_line_in[utf8v_pkg::ERROR_LINE_WIDTH-1:0];
      end else begin : g_ext
         assign err_line_sat = utf8v_pkg::ERROR_LINE_WIDTH'(err_line_in);
      end
   endgenerate

   always_comb begin
      if (bom_seen_in) begin
         verdict.status     = utf8v_pkg::STATUS_BOM;
         verdict.error_line = '0;
         verdict.bad_value  = '0;
      end else if (mode_in == MODE_ERROR) begin
         verdict.status     = utf8v_pkg::STATUS_BAD;
         verdict.error_line = err_line_sat;
         verdict.bad_value  = err_value_in;
      end else begin
         verdict.status     = utf8v_pkg::STATUS_OK;
         verdict.error_line = '0;
         verdict.bad_value  = '0;
      end
   end

   assign verdict_eos   = fire && end_of_stream;
   assign verdict_valid = verdict_eos;

   always_ff @(posedge clock) begin
      if (reset || verdict_eos) begin
         line_count_ff   <= LINE_ONE;
         lead_line_ff    <= '0;
         err_line_ff     <= '0;
         lead_value_ff   <= '0;
         second_value_ff <= '0;
         err_value_ff    <= '0;
         pending_ff      <= '0;
         prefix_pos_ff   <= '0;
         bom_seen_ff     <= 1'b0;
         mode_ff         <= MODE_SCANNING;
      end else if (fire) begin
         line_count_ff   <= line_count_in;
         lead_line_ff    <= lead_line_in;
         err_line_ff     <= err_line_in;
         lead_value_ff   <= lead_value_in;
         second_value_ff <= second_value_in;
         err_value_ff    <= err_value_in;
         pending_ff      <= pending_in;
         prefix_pos_ff   <= prefix_pos_in;
         bom_seen_ff     <= bom_seen_in;
         mode_ff         <= mode_in;
      end
   end

endmodule

`default_nettype wire

/* sv/utf8v_out_stage.sv */
`default_nettype none

// Result register: holds one verdict until the consumer takes it.
module utf8v_out_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load,
   input  wire utf8v_pkg::verdict_type verdict,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output utf8v_pkg::verdict_type      verdict_out,
   output logic                        free
);

   logic                   valid_ff;
   utf8v_pkg::verdict_type verdict_ff;

   assign free        = !valid_ff || !rsp_stall;
   assign rsp_valid   = valid_ff;
   assign verdict_out = verdict_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (free && load) begin
         verdict_ff <= verdict;
      end
   end

endmodule

`default_nettype wire

/* sv/utf8_stream_validator_unit.sv */
`default_nettype none

// A request is registered in the input register at acceptance; its verdict
//   (final byte only) is loaded into the result register as the byte advances.
// Throughput: one byte per cycle, set by the combinational check between the input
//   register and the result register; a stalled result holds the input stage.
// Reset: synchronous, active high; clears both stages and the stream state.

module utf8_stream_validator_unit #(
   parameter int LINE_WIDTH = 24
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel: one stream byte per request
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [7:0]                           req_data_byte,
   input  wire logic                                 req_end_of_stream,
   // result channel: one verdict per stream
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output utf8v_pkg::status_type                     rsp_status,
   output logic [utf8v_pkg::ERROR_LINE_WIDTH-1:0]    rsp_error_line,
   output logic [7:0]                                rsp_bad_value
);

   // Input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;

   logic                   advance;
   logic                   out_free;
   logic                   verdict_valid;
   utf8v_pkg::verdict_type verdict;
   utf8v_pkg::verdict_type verdict_q;

   // A byte moves on unless it carries a verdict and the result register
   // is still occupied by an untaken one.
   assign advance   = in_valid_ff && (!in_eos_ff || out_free);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_data_byte;
         in_eos_ff  <= req_end_of_stream;
      end
   end

   utf8v_scan #(
      .LINE_WIDTH (LINE_WIDTH)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance),
      .data_byte     (in_byte_ff),
      .end_of_stream (in_eos_ff),
      .verdict       (verdict),
      .verdict_valid (verdict_valid)
   );

   utf8v_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (verdict_valid),
      .verdict     (verdict),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .verdict_out (verdict_q),
      .free        (out_free)
   );

   assign rsp_status     = verdict_q.status;
   assign rsp_error_line = verdict_q.error_line;
   assign rsp_bad_value  = verdict_q.bad_value;

   // A stall toward the producer only ever comes from a held byte.
   a_stall_has_byte : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && in_eos_ff)
      else $error("request stall without a held final byte");

   // A verdict is only handed over on a final byte that found room.
   a_verdict_on_eos : assert property (@(posedge clock) disable iff (reset)
      verdict_valid |-> advance && in_eos_ff && out_free)
      else $error("verdict produced off the final byte");

   // Clean or mark verdicts carry no error detail.
   a_clean_detail : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == utf8v_pkg::STATUS_OK ||
                    rsp_status == utf8v_pkg::STATUS_BOM)
      |-> rsp_error_line == '0 && rsp_bad_value == '0)
      else $error("error detail on a clean verdict");

   // A bad lead byte is never ASCII and always has a line of one or more.
   a_bad_detail : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == utf8v_pkg::STATUS_BAD
      |-> rsp_bad_value[7] && rsp_error_line != '0)
      else $error("implausible error detail");

   // A verdict taken by the consumer leaves the result register empty
   // unless a new final byte was passed on in the same cycle.
   a_result_drains : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !verdict_valid |=> !rsp_valid)
      else $error("result register did not drain");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none

// Stream-level check of the UTF-8 validator.
// Bytes go in one per request; only the request that closes a stream
// produces a verdict. A local copy of the validator state predicts every
// verdict when the closing byte is accepted, and a monitor on the result
// channel compares what comes out against the oldest pending prediction.

module tb_top;

   localparam int LINE_W      = 24;       // matches the unit's default
   localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run
   localparam int HOLD_CYCLES = 200;      // long receiver hold-off
   localparam int MAX_PRINTS  = 40;

   localparam logic [7:0] BYTE_NUL     = 8'h00;
   localparam logic [7:0] BYTE_NEWLINE = 8'h0A;
   localparam logic [7:0] BOM_B0       = 8'hEF;
   localparam logic [7:0] BOM_B1       = 8'hBB;
   localparam logic [7:0] BOM_B2       = 8'hBF;

   typedef enum logic [1:0] {
      SCAN_RUN,       // still checking
      SCAN_STOPPED,   // zero byte seen at a sequence start
      SCAN_FAILED     // first bad lead latched
   } scan_mode_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [7:0] req_data_byte;
   logic req_end_of_stream;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   utf8v_pkg::status_type rsp_status;
   logic [utf8v_pkg::ERROR_LINE_WIDTH-1:0] rsp_error_line;
   logic [7:0] rsp_bad_value;

   utf8_stream_validator_unit #(.LINE_WIDTH(LINE_W)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_error_line    (rsp_error_line),
      .rsp_bad_value     (rsp_bad_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Validator state as the checker sees it
   // ------------------------------------------------------------------
   logic [LINE_W-1:0] line_count;
   logic [LINE_W-1:0] lead_line;
   logic [LINE_W-1:0] fail_line;
   logic [7:0]        lead_byte;
   logic [7:0]        second_byte;
   logic [7:0]        fail_byte;
   logic [1:0]        pending;      // continuation bytes still owed
   logic [1:0]        prefix_pos;   // 3 = BOM match finished
   logic              bom_found;
   scan_mode_type     mode;

   utf8v_pkg::verdict_type expected_verdicts[$];
   utf8v_pkg::verdict_type verdict_want;

   int error_count = 0;
   int items_sent  = 0;
   int cycle_count = 0;

   task automatic log_mismatch(input string msg);
      if (error_count < MAX_PRINTS)
         $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic clear_stream();
      line_count  = LINE_W'(1);
      lead_line   = '0;
      fail_line   = '0;
      lead_byte   = '0;
      second_byte = '0;
      fail_byte   = '0;
      pending     = '0;
      prefix_pos  = '0;
      bom_found   = 1'b0;
      mode        = SCAN_RUN;
   endtask

   task automatic mark_bad(input logic [LINE_W-1:0] line, input logic [7:0] value);
      mode      = SCAN_FAILED;
      fail_line = line;
      fail_byte = value;
      pending   = '0;
   endtask

   // Advance the stream state by one accepted byte; queue a verdict on the
   // closing byte and start over for the next stream.
   task automatic predict_byte(input logic [7:0] b, input logic eos);
      logic [7:0]  bom_next;
      logic [2:0]  seq_len;
      logic [2:0]  pos;
      logic        bad;
      utf8v_pkg::verdict_type v;

      // BOM match runs on every byte, even once checking has stopped
      if (prefix_pos < 3) begin
         bom_next = (prefix_pos == 0) ? BOM_B0 : (prefix_pos == 1) ? BOM_B1 : BOM_B2;
         if (b == bom_next) begin
            if (prefix_pos == 2)
               bom_found = 1'b1;
            prefix_pos++;
         end else begin
            prefix_pos = 2'd3;
         end
      end

      if (mode == SCAN_RUN) begin
         if (pending == 0) begin
            lead_byte = b;
            lead_line = line_count;
            if (b == BYTE_NUL) begin
               mode = SCAN_STOPPED;
            end else if (b < 8'h80) begin
               if (b == BYTE_NEWLINE && line_count != '1)
                  line_count++;
            end else if ((b & 8'hE0) == 8'hC0) begin
               if ((b & 8'hFE) == 8'hC0)
                  mark_bad(line_count, b);   // overlong two-byte lead
               else
                  pending = 2'd1;
            end else if ((b & 8'hF0) == 8'hE0) begin
               pending = 2'd2;
            end else if ((b & 8'hF8) == 8'hF0) begin
               if (b > 8'hF4)
                  mark_bad(line_count, b);   // beyond U+10FFFF
               else
                  pending = 2'd3;
            end else begin
               mark_bad(line_count, b);      // stray continuation or F8..FF
            end
         end else begin
            seq_len = ((lead_byte & 8'hE0) == 8'hC0) ? 3'd2 :
                      ((lead_byte & 8'hF0) == 8'hE0) ? 3'd3 : 3'd4;
            pos = seq_len - {1'b0, pending};
            bad = (b & 8'hC0) != 8'h80;
            if (pos == 1) begin
               if (lead_byte == 8'hE0 && (b & 8'hE0) == 8'h80) bad = 1'b1;
               if (lead_byte == 8'hED && (b & 8'hE0) == 8'hA0) bad = 1'b1;
               if (lead_byte == 8'hF0 && (b & 8'hF0) == 8'h80) bad = 1'b1;
               if (lead_byte == 8'hF4 && b > 8'h8F) bad = 1'b1;
               second_byte = b;
            end else if (pos == 2 && seq_len == 3) begin
               // U+FFFE / U+FFFF
               if (lead_byte == 8'hEF && second_byte == 8'hBF && (b & 8'hFE) == 8'hBE)
                  bad = 1'b1;
            end
            if (bad)
               mark_bad(lead_line, lead_byte);
            else
               pending--;
         end
      end

      if (eos) begin
         // stream ended inside a sequence
         if (mode == SCAN_RUN && pending != 0)
            mark_bad(lead_line, lead_byte);
         v = '0;
         if (bom_found) begin
            v.status = utf8v_pkg::STATUS_BOM;
         end else if (mode == SCAN_FAILED) begin
            v.status     = utf8v_pkg::STATUS_BAD;
            v.error_line = fail_line;
            v.bad_value  = fail_byte;
         end else begin
            v.status = utf8v_pkg::STATUS_OK;
         end
         expected_verdicts.insert(expected_verdicts.size(), v);
         clear_stream();
      end
   endtask

   // ------------------------------------------------------------------
   // Result monitor
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            log_mismatch($sformatf("unexpected verdict status %0d line %0d value %02h",
                                   rsp_status, rsp_error_line, rsp_bad_value));
         end else begin
            verdict_want = expected_verdicts.pop_front();
            if (rsp_status !== verdict_want.status)
               log_mismatch($sformatf("status %0d, expected %0d",
                                      rsp_status, verdict_want.status));
            if (rsp_error_line !== verdict_want.error_line)
               log_mismatch($sformatf("error line %0d, expected %0d",
                                      rsp_error_line, verdict_want.error_line));
            if (rsp_bad_value !== verdict_want.bad_value)
               log_mismatch($sformatf("bad_value %02h, expected %02h",
                                      rsp_bad_value, verdict_want.bad_value));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Receiver: clustered stalls, plus a long hold-off on demand
   // ------------------------------------------------------------------
   int   stall_pct     = 0;
   int   stall_run     = 0;
   logic stall_level   = 1'b0;
   int   hold_requests = 0;   // bumped by the test
   int   holds_taken   = 0;   // tracked here only
   int   hold_left     = 0;

   always @(negedge clock) begin
      if (hold_requests != holds_taken) begin
         holds_taken++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else begin
         if (stall_run == 0) begin
            stall_level = ($urandom_range(1, 100) <= stall_pct);
            stall_run   = $urandom_range(1, 6);
         end
         stall_run--;
         rsp_stall = stall_level;
      end
   end

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------
   int gap_max    = 0;
   int burst_left = 0;
   logic [7:0] stream_bytes[$];

   // Entered and left at a falling edge. Valid stays high across
   // back-to-back requests.
   task automatic send_byte(input logic [7:0] b, input logic eos);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_valid         = 1'b1;
      req_data_byte     = b;
      req_end_of_stream = eos;
      do @(posedge clock); while (req_stall);
      predict_byte(b, eos);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_bytes.size(); i++)
         send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (expected_verdicts.size() != 0)
         @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Stream builders
   // ------------------------------------------------------------------
   function automatic logic [7:0] cont_byte();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   // append one byte to the stream under construction
   task automatic add_byte(input logic [7:0] b);
      stream_bytes.insert(stream_bytes.size(), b);
   endtask

   // one well-formed character
   task automatic add_valid_char();
      logic [7:0] lead;
      logic [7:0] second;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            add_byte(8'($urandom_range(1, 127)));
         end
         4, 5: begin
            add_byte(8'($urandom_range(8'hC2, 8'hDF)));
            add_byte(cont_byte());
         end
         6, 7: begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            if (lead == 8'hE0)      second = 8'($urandom_range(8'hA0, 8'hBF));
            else if (lead == 8'hED) second = 8'($urandom_range(8'h80, 8'h9F));
            else                    second = cont_byte();
            add_byte(lead);
            add_byte(second);
            if (lead == 8'hEF && second == 8'hBF)
               add_byte(8'($urandom_range(8'h80, 8'hBD)));
            else
               add_byte(cont_byte());
         end
         8: begin
            lead = 8'($urandom_range(8'hF0, 8'hF4));
            if (lead == 8'hF0)      second = 8'($urandom_range(8'h90, 8'hBF));
            else if (lead == 8'hF4) second = 8'($urandom_range(8'h80, 8'h8F));
            else                    second = cont_byte();
            add_byte(lead);
            add_byte(second);
            add_byte(cont_byte());
            add_byte(cont_byte());
         end
         default: add_byte(BYTE_NEWLINE);
      endcase
   endtask

   function automatic logic [7:0] multi_lead();
      case ($urandom_range(0, 2))
         0:       return 8'($urandom_range(8'hC2, 8'hDF));
         1:       return 8'($urandom_range(8'hE1, 8'hEC));
         default: return 8'($urandom_range(8'hF1, 8'hF3));
      endcase
   endfunction

   // one malformed piece
   task automatic add_bad_piece();
      case ($urandom_range(0, 9))
         0: add_byte(cont_byte());
         1: begin
            add_byte(8'($urandom_range(8'hC0, 8'hC1)));
            add_byte(cont_byte());
         end
         2: add_byte(8'($urandom_range(8'hF5, 8'hFF)));
         3: begin
            add_byte(8'hE0);
            add_byte(8'($urandom_range(8'h80, 8'h9F)));
            add_byte(cont_byte());
         end
         4: begin
            add_byte(8'hF0);
            add_byte(8'($urandom_range(8'h80, 8'h8F)));
            add_byte(cont_byte());
            add_byte(cont_byte());
         end
         5: begin
            add_byte(8'hED);
            add_byte(8'($urandom_range(8'hA0, 8'hBF)));
            add_byte(cont_byte());
         end
         6: begin
            add_byte(8'hEF);
            add_byte(8'hBF);
            add_byte(8'($urandom_range(8'hBE, 8'hBF)));
         end
         7: begin
            add_byte(8'hF4);
            add_byte(8'($urandom_range(8'h90, 8'hBF)));
            add_byte(cont_byte());
            add_byte(cont_byte());
         end
         8: begin
            // cut short by a non-continuation
            add_byte(multi_lead());
            if ($urandom_range(0, 1))
               add_byte(8'($urandom_range(8'h20, 8'h7E)));
            else
               add_byte(multi_lead());
         end
         default: begin
            // cut short by a zero byte
            add_byte(multi_lead());
            add_byte(BYTE_NUL);
         end
      endcase
   endtask

   task automatic build_random_stream();
      int kind;
      int n;
      int cut;
      logic [7:0] lead;
      stream_bytes.delete();
      kind = $urandom_range(0, 19);
      n    = $urandom_range(0, 10);
      // full or partial BOM up front now and then
      if ($urandom_range(0, 7) == 0) begin
         add_byte(BOM_B0);
         if ($urandom_range(0, 3) != 0) add_byte(BOM_B1);
         if ($urandom_range(0, 3) != 0) add_byte(BOM_B2);
      end
      if (kind < 12) begin
         repeat (n) add_valid_char();
      end else if (kind < 16) begin
         cut = $urandom_range(0, n);
         for (int i = 0; i < n; i++) begin
            if (i == cut) add_bad_piece();
            add_valid_char();
         end
         if (cut == n) add_bad_piece();
      end else if (kind < 18) begin
         repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      end else begin
         // stream ends inside a sequence
         repeat (n) add_valid_char();
         lead = multi_lead();
         add_byte(lead);
         if (lead >= 8'hE0 && $urandom_range(0, 1))
            add_byte(cont_byte());
      end
      // zero byte with trailing junk, which must be ignored
      if ($urandom_range(0, 9) == 0) begin
         add_byte(BYTE_NUL);
         repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
      end
      if (stream_bytes.size() == 0)
         add_byte(8'($urandom_range(1, 127)));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      gap_max   = 0;
      stall_pct = 0;
      // BOM wins over the stray continuation after it
      stream_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'h80};
      send_stream();
      // overlong three-byte form on line 2
      stream_bytes = '{BYTE_NEWLINE, 8'hE0, 8'h80};
      send_stream();
      // surrogate
      stream_bytes = '{8'hED, 8'hA0, 8'h80};
      send_stream();
      // U+FFFE
      stream_bytes = '{8'hEF, 8'hBF, 8'hBE};
      send_stream();
      // above U+10FFFF
      stream_bytes = '{8'hF4, 8'h90};
      send_stream();
      // zero byte stops checking, FF after it is ignored
      stream_bytes = '{8'h41, BYTE_NUL, 8'hFF};
      send_stream();
      // one-byte stream ending inside a sequence
      stream_bytes = '{8'hC3};
      send_stream();
      // cut short by an ASCII byte
      stream_bytes = '{8'hE2, 8'h82, 8'h41};
      send_stream();
      // four-byte character, then newline: clean
      stream_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80, BYTE_NEWLINE};
      send_stream();
      wait_drained();
   endtask

   task automatic test_random_streams(input int n_bytes, input int gaps, input int stall);
      int stop_at;
      gap_max   = gaps;
      stall_pct = stall;
      stop_at   = items_sent + n_bytes;
      while (items_sent < stop_at) begin
         build_random_stream();
         send_stream();
      end
      wait_drained();
   endtask

   // Hold the result side off long enough for the unit to back up into
   // its input, while one-byte streams keep arriving.
   task automatic test_backpressure();
      gap_max   = 0;
      stall_pct = 0;
      hold_requests++;
      repeat (40) begin
         if ($urandom_range(0, 3) == 0)
            send_byte(8'($urandom_range(8'h80, 8'hFF)), 1'b1);
         else
            send_byte(8'($urandom_range(0, 127)), 1'b1);
      end
      wait_drained();
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_data_byte     = '0;
      req_end_of_stream = 1'b0;
      clear_stream();
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_streams(400, 0, 0);    // full rate, no stalls
      test_backpressure();
      test_random_streams(600, 4, 30);   // bursty sender, moderate stalls
      test_random_streams(400, 2, 75);   // heavy stalls

      req_valid = 1'b0;
      repeat (6) @(negedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
sv/utf8v_pkg.sv
sv/utf8v_scan.sv
sv/utf8v_out_stage.sv
sv/utf8_stream_validator_unit.sv
dv/tb_top.sv
